### hw/rtl/cct_pkg.sv
// Shared constants, payload types and arithmetic helpers for the circle collision test.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package cct_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned RAD_W      = COORD_BITS - 1;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;      // difference of two coordinates
  localparam int unsigned SQ_W       = 2 * COORD_BITS;      // square of a difference
  localparam int unsigned XP_W       = SQ_W + 1;            // signed product of two differences
  localparam int unsigned A_W        = SQ_W + 1;            // sum of two squares
  localparam int unsigned BH_W       = SQ_W + 2;            // signed half linear term
  localparam int unsigned G_W        = SQ_W + 2;            // signed end-point value
  localparam int unsigned PROD_W     = 2 * A_W;             // final discriminant products

  localparam logic OP_CIRCLE  = 1'b0;
  localparam logic OP_SEGMENT = 1'b1;

  // Beat handed from the sum stage to the root test.
  typedef struct packed {
    logic                          op;
    logic                          degen;
    logic [A_W-1:0]                a;
    logic signed [BH_W-1:0]        bh;
    logic signed [G_W-1:0]         g0;
    logic signed [G_W-1:0]         g1;
  } cct_sums_t;

  function automatic logic [SQ_W-1:0] sq_diff(input logic signed [DIFF_W-1:0] x);
    logic signed [2*DIFF_W-1:0] p;
    p = x * x;
    return p[SQ_W-1:0];
  endfunction

  function automatic logic signed [XP_W-1:0] mul_diff(input logic signed [DIFF_W-1:0] x,
                                                     input logic signed [DIFF_W-1:0] y);
    logic signed [2*DIFF_W-1:0] p;
    p = x * y;
    return p[XP_W-1:0];
  endfunction

endpackage

### hw/rtl/cct_ifs.sv
// Query and result channel interfaces for the circle collision test.
// Depends on cct_pkg for field widths.
`timescale 1ns / 1ps

interface cct_query_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic signed [cct_pkg::COORD_BITS-1:0] center_x;
  logic signed [cct_pkg::COORD_BITS-1:0] center_y;
  logic [cct_pkg::RAD_W-1:0]            radius_a;
  logic signed [cct_pkg::COORD_BITS-1:0] p_x;
  logic signed [cct_pkg::COORD_BITS-1:0] p_y;
  logic signed [cct_pkg::COORD_BITS-1:0] q_x;
  logic signed [cct_pkg::COORD_BITS-1:0] q_y;
  logic [cct_pkg::RAD_W-1:0]            radius_b;

  modport source (output valid, opcode, center_x, center_y, radius_a, p_x, p_y, q_x, q_y,
                  radius_b, input ready);
  modport sink   (input valid, opcode, center_x, center_y, radius_a, p_x, p_y, q_x, q_y,
                  radius_b, output ready);
endinterface

interface cct_result_if;
  logic valid;
  logic ready;
  logic hit;
  logic status;

  modport source (output valid, hit, status, input ready);
  modport sink   (input valid, hit, status, output ready);
endinterface

### hw/rtl/circle_collision_test_top.sv
// Circle collision test: an accepted query passes the difference, product and sum registers, then the decision
// and result registers of cct_root_test, before a valid result beat. Throughput one query per cycle; a stalled
// result holds the pipe, bubbles collapse on the way. Critical stages: seventeen-bit products, then one 33 by 33
// bit product pair, then a wide compare. Reset clears only the valid bits; payload registers are not reset.
// Depends on cct_pkg, cct_ifs and cct_root_test.
`timescale 1ns / 1ps

module circle_collision_test_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  cct_query_if.sink     req_i,
  cct_result_if.source  rsp_o
);

  localparam int unsigned N = cct_pkg::COORD_BITS;

  // Stage 1: coordinate differences and the radius to square.
  logic                                  v1_q;
  logic                                  op1_q;
  logic                                  degen1_q;
  logic signed [cct_pkg::DIFF_W-1:0]     dx1_q, dy1_q, fx1_q, fy1_q, ex1_q, ey1_q;
  logic signed [cct_pkg::DIFF_W-1:0]     dx1_d, dy1_d, fx1_d, fy1_d, ex1_d, ey1_d;
  logic [N-1:0]                          r1_q, r1_d;
  logic                                  ready1;

  // Stage 2: squares and cross products.
  logic                                  v2_q;
  logic                                  op2_q;
  logic                                  degen2_q;
  logic [cct_pkg::SQ_W-1:0]              dx2_q, dy2_q, fx2_q, fy2_q, ex2_q, ey2_q, r2_q;
  logic signed [cct_pkg::XP_W-1:0]       fxdx_q, fydy_q;
  logic                                  ready2;

  // Stage 3: sums that form the quadratic.
  logic                                  v3_q;
  cct_pkg::cct_sums_t                    s3_q, s3_d;
  logic                                  ready3;
  logic                                  ready4;

  assign ready3  = !v3_q || ready4;
  assign ready2  = !v2_q || ready3;
  assign ready1  = !v1_q || ready2;
  assign req_i.ready = ready1;

  // For the circle test, f = P - C is the negated center offset, so its square is shared;
  // the radius is ra + rb there and ra alone for the segment test.
  always_comb begin
    dx1_d = cct_pkg::DIFF_W'(req_i.q_x) - cct_pkg::DIFF_W'(req_i.p_x);
    dy1_d = cct_pkg::DIFF_W'(req_i.q_y) - cct_pkg::DIFF_W'(req_i.p_y);
    fx1_d = cct_pkg::DIFF_W'(req_i.p_x) - cct_pkg::DIFF_W'(req_i.center_x);
    fy1_d = cct_pkg::DIFF_W'(req_i.p_y) - cct_pkg::DIFF_W'(req_i.center_y);
    ex1_d = cct_pkg::DIFF_W'(req_i.q_x) - cct_pkg::DIFF_W'(req_i.center_x);
    ey1_d = cct_pkg::DIFF_W'(req_i.q_y) - cct_pkg::DIFF_W'(req_i.center_y);
    if (req_i.opcode == cct_pkg::OP_CIRCLE) begin
      r1_d = N'(req_i.radius_a) + N'(req_i.radius_b);
    end else begin
      r1_d = N'(req_i.radius_a);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= req_i.valid;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Load stage 1 on an accepted beat.
  always_ff @(posedge clk_i) begin
    if (ready1 && req_i.valid) begin
      op1_q    <= req_i.opcode;
      degen1_q <= (req_i.p_x == req_i.q_x) && (req_i.p_y == req_i.q_y);
      dx1_q    <= dx1_d;
      dy1_q    <= dy1_d;
      fx1_q    <= fx1_d;
      fy1_q    <= fy1_d;
      ex1_q    <= ex1_d;
      ey1_q    <= ey1_d;
      r1_q     <= r1_d;
    end
  end

  // Advance into stage 2: one multiplier per product.
  always_ff @(posedge clk_i) begin
    if (ready2 && v1_q) begin
      op2_q    <= op1_q;
      degen2_q <= degen1_q;
      dx2_q    <= cct_pkg::sq_diff(dx1_q);
      dy2_q    <= cct_pkg::sq_diff(dy1_q);
      fx2_q    <= cct_pkg::sq_diff(fx1_q);
      fy2_q    <= cct_pkg::sq_diff(fy1_q);
      ex2_q    <= cct_pkg::sq_diff(ex1_q);
      ey2_q    <= cct_pkg::sq_diff(ey1_q);
      r2_q     <= cct_pkg::SQ_W'(r1_q) * cct_pkg::SQ_W'(r1_q);
      fxdx_q   <= cct_pkg::mul_diff(fx1_q, dx1_q);
      fydy_q   <= cct_pkg::mul_diff(fy1_q, dy1_q);
    end
  end

  // a = d.d, bh = f.d, g0 and g1 = value of the quadratic at each end of the segment.
  always_comb begin
    s3_d.op    = op2_q;
    s3_d.degen = degen2_q;
    s3_d.a     = cct_pkg::A_W'(dx2_q) + cct_pkg::A_W'(dy2_q);
    s3_d.bh    = cct_pkg::BH_W'(fxdx_q) + cct_pkg::BH_W'(fydy_q);
    s3_d.g0    = cct_pkg::G_W'(fx2_q) + cct_pkg::G_W'(fy2_q) - cct_pkg::G_W'(r2_q);
    s3_d.g1    = cct_pkg::G_W'(ex2_q) + cct_pkg::G_W'(ey2_q) - cct_pkg::G_W'(r2_q);
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  // Stages 4 and 5: decision, discriminant products and the result register.
  cct_root_test u_root_test (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sums_valid_i (v3_q),
    .sums_ready_o (ready4),
    .sums_i       (s3_q),
    .rsp_o        (rsp_o)
  );

endmodule

### hw/rtl/cct_root_test.sv
// Root test: end-point signs, vertex range and the exact discriminant compare.
// Depends on cct_pkg and cct_result_if; two register stages, the second is the result register.
`timescale 1ns / 1ps

module cct_root_test (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sums_valid_i,
  output logic                sums_ready_o,
  input  cct_pkg::cct_sums_t  sums_i,
  cct_result_if.source        rsp_o
);

  logic                            v4_q;
  logic                            need_cmp_q, need_cmp_d;
  logic                            pre_hit_q, pre_hit_d;
  logic                            status_q, status_d;
  logic [cct_pkg::PROD_W-1:0]      bb_q, bb_d;
  logic [cct_pkg::PROD_W-1:0]      ag_q, ag_d;
  logic                            ready4;

  logic                            out_valid_q;
  logic                            hit_q, hit_d;
  logic                            out_status_q;
  logic                            ready_out;

  logic [cct_pkg::BH_W-1:0]        nbh;
  logic [cct_pkg::BH_W:0]          vtx;
  logic [cct_pkg::A_W-1:0]         babs;
  logic [cct_pkg::A_W-1:0]         g0u;
  logic                            g0_zero, g1_zero, g0_neg, g1_neg;

  assign ready_out    = !out_valid_q || rsp_o.ready;
  assign ready4       = !v4_q || ready_out;
  assign sums_ready_o = ready4;

  // End-point classification and products; the products only matter when both ends are outside.
  always_comb begin
    nbh     = ~sums_i.bh + cct_pkg::BH_W'(1);
    babs    = nbh[cct_pkg::A_W-1:0];
    g0u     = sums_i.g0[cct_pkg::A_W-1:0];
    vtx     = {sums_i.bh[cct_pkg::BH_W-1], sums_i.bh} + (cct_pkg::BH_W+1)'(sums_i.a);
    g0_zero = (sums_i.g0 == '0);
    g1_zero = (sums_i.g1 == '0);
    g0_neg  = sums_i.g0[cct_pkg::G_W-1];
    g1_neg  = sums_i.g1[cct_pkg::G_W-1];
    bb_d    = cct_pkg::PROD_W'(babs) * cct_pkg::PROD_W'(babs);
    ag_d    = cct_pkg::PROD_W'(sums_i.a) * cct_pkg::PROD_W'(g0u);

    need_cmp_d = 1'b0;
    pre_hit_d  = 1'b0;
    status_d   = 1'b0;
    if (sums_i.op == cct_pkg::OP_CIRCLE) begin
      // g0 here is distance squared minus (ra + rb) squared
      pre_hit_d = g0_neg || g0_zero;
    end else if (sums_i.degen) begin
      status_d = 1'b1;
    end else if (g0_zero || g1_zero || (g0_neg != g1_neg)) begin
      pre_hit_d = 1'b1;
    end else if (g0_neg) begin
      pre_hit_d = 1'b0;
    end else if (!sums_i.bh[cct_pkg::BH_W-1] && (sums_i.bh != '0)) begin
      pre_hit_d = 1'b0;
    end else if (vtx[cct_pkg::BH_W]) begin
      pre_hit_d = 1'b0;
    end else begin
      need_cmp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ready4) begin
      v4_q <= sums_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready4 && sums_valid_i) begin
      need_cmp_q <= need_cmp_d;
      pre_hit_q  <= pre_hit_d;
      status_q   <= status_d;
      bb_q       <= bb_d;
      ag_q       <= ag_d;
    end
  end

  assign hit_d = need_cmp_q ? (bb_q >= ag_q) : pre_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_out) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_out && v4_q) begin
      hit_q        <= hit_d;
      out_status_q <= status_q;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.hit    = hit_q;
  assign rsp_o.status = out_status_q;

endmodule

### tb/cct_collision_checker.sv
// Checker for the circle collision test: watches the query and result channels,
// predicts hit and status per query beat and compares them in order. Needs cct_pkg, cct_ifs.
`timescale 1ns / 1ps

module cct_collision_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  cct_query_if  query_mon,
  cct_result_if result_mon,
  output int    errors_o,
  output int    pending_o,
  output int    queries_o,
  output int    segments_o,
  output int    degen_o,
  output int    hits_o
);

  typedef struct packed {
    logic hit;
    logic status;
  } verdict_t;

  verdict_t expected_verdicts[$];
  int       error_count   = 0;
  int       query_count   = 0;
  int       segment_count = 0;
  int       degen_count   = 0;
  int       hit_count     = 0;

  // Exact root test without square roots: both ends are compared first, then the
  // vertex position and the discriminant in 128 bits.
  function automatic logic segment_meets_circle(longint cx, longint cy, longint r,
                                                longint px, longint py,
                                                longint qx, longint qy);
    longint      dx, dy, fx, fy, ex, ey;
    longint      span_sq, half_lin, r_sq, at_start, at_end;
    logic [127:0] lin_abs, lin_sq, span_prod;
    dx       = qx - px;
    dy       = qy - py;
    fx       = px - cx;
    fy       = py - cy;
    ex       = qx - cx;
    ey       = qy - cy;
    span_sq  = dx * dx + dy * dy;
    half_lin = fx * dx + fy * dy;
    r_sq     = r * r;
    at_start = fx * fx + fy * fy - r_sq;
    at_end   = ex * ex + ey * ey - r_sq;
    if (at_start == 0 || at_end == 0) return 1'b1;
    if ((at_start < 0) != (at_end < 0)) return 1'b1;
    if (at_start < 0) return 1'b0;
    if (half_lin > 0 || -half_lin > span_sq) return 1'b0;
    lin_abs   = 128'(-half_lin);
    lin_sq    = lin_abs * lin_abs;
    span_prod = 128'(span_sq) * 128'(at_start);
    return lin_sq >= span_prod;
  endfunction

  function automatic verdict_t collide_verdict(logic op,
                                               longint cx, longint cy, longint ra,
                                               longint px, longint py,
                                               longint qx, longint qy, longint rb);
    verdict_t v;
    longint   dx, dy, reach;
    v = '0;
    if (op == cct_pkg::OP_CIRCLE) begin
      dx    = cx - px;
      dy    = cy - py;
      reach = ra + rb;
      v.hit = (dx * dx + dy * dy <= reach * reach);
    end else if (px == qx && py == qy) begin
      v.status = 1'b1;
    end else begin
      v.hit = segment_meets_circle(cx, cy, ra, px, py, qx, qy);
    end
    return v;
  endfunction

  always @(posedge clk_i) begin : watch
    verdict_t want;
    if (rst_ni) begin
      // Retire first: a beat entering this edge cannot leave at the same edge.
      if (result_mon.valid && result_mon.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result beat with no query outstanding");
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (result_mon.hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, result_mon.hit);
            error_count++;
          end
          if (result_mon.status !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, result_mon.status);
            error_count++;
          end
          if (result_mon.hit === 1'b1) hit_count++;
        end
      end
      if (query_mon.valid && query_mon.ready) begin
        want = collide_verdict(query_mon.opcode,
                               longint'(query_mon.center_x), longint'(query_mon.center_y),
                               longint'(query_mon.radius_a),
                               longint'(query_mon.p_x), longint'(query_mon.p_y),
                               longint'(query_mon.q_x), longint'(query_mon.q_y),
                               longint'(query_mon.radius_b));
        expected_verdicts.push_back(want);
        query_count++;
        if (query_mon.opcode == cct_pkg::OP_SEGMENT) segment_count++;
        if (want.status) degen_count++;
      end
    end
    errors_o   <= error_count;
    pending_o  <= expected_verdicts.size();
    queries_o  <= query_count;
    segments_o <= segment_count;
    degen_o    <= degen_count;
    hits_o     <= hit_count;
  end

endmodule

### tb/circle_collision_test_top_tb.sv
// Testbench top for circle_collision_test_top: makes query stimulus and result back-pressure,
// and gives the verdict. Needs cct_pkg, cct_ifs, the block itself and cct_collision_checker.
`timescale 1ns / 1ps

module circle_collision_test_top_tb;

  localparam int CW = cct_pkg::COORD_BITS;
  localparam int RW = cct_pkg::RAD_W;

  typedef struct {
    logic                 opcode;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic        [RW-1:0] radius_a;
    logic signed [CW-1:0] p_x;
    logic signed [CW-1:0] p_y;
    logic signed [CW-1:0] q_x;
    logic signed [CW-1:0] q_y;
    logic        [RW-1:0] radius_b;
  } query_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Bumped by the stimulus to ask the result side for one long hold-off.
  int hold_off_seq = 0;

  int errors, pending, queries, segments, degen, hits;

  cct_query_if  req_if ();
  cct_result_if rsp_if ();

  circle_collision_test_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  cct_collision_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .query_mon  (req_if),
    .result_mon (rsp_if),
    .errors_o   (errors),
    .pending_o  (pending),
    .queries_o  (queries),
    .segments_o (segments),
    .degen_o    (degen),
    .hits_o     (hits)
  );

  // 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #10_000_000;
    $display("circle_collision_test_top: mismatch");
    $finish;
  end

  // Pack loose integers into a query; upper bits drop off at the field widths.
  function automatic query_t mk_query(logic op, int cx, int cy, int ra,
                                      int px, int py, int qx, int qy, int rb);
    query_t q;
    q.opcode   = op;
    q.center_x = cx[CW-1:0];
    q.center_y = cy[CW-1:0];
    q.radius_a = ra[RW-1:0];
    q.p_x      = px[CW-1:0];
    q.p_y      = py[CW-1:0];
    q.q_x      = qx[CW-1:0];
    q.q_y      = qy[CW-1:0];
    q.radius_b = rb[RW-1:0];
    return q;
  endfunction

  // Random offset in [-lim, lim].
  function automatic int near_offset(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // 35 percent is raw full-range noise; the rest places P and Q near the center at a
  // scale comparable to the radii, so hits, misses, tangents and degenerate segments all show.
  function automatic query_t rand_query();
    query_t q;
    int     mode, span;
    q      = mk_query(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom);
    mode   = $urandom_range(0, 99);
    if (mode >= 35) begin
      span       = (mode < 80) ? $urandom_range(1, 600) : $urandom_range(1, 12000);
      q.radius_a = RW'($urandom_range(0, span));
      q.radius_b = RW'($urandom_range(0, span));
      q.p_x      = q.center_x + CW'(near_offset(2 * span));
      q.p_y      = q.center_y + CW'(near_offset(2 * span));
      q.q_x      = q.center_x + CW'(near_offset(2 * span));
      q.q_y      = q.center_y + CW'(near_offset(2 * span));
      if (mode >= 94) begin
        q.q_x = q.p_x;
        q.q_y = q.p_y;
      end
    end
    return q;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Call at a rising edge; returns at the edge that accepts the beat. During a gap
  // valid drops and the payload carries junk, which the block must not take.
  task automatic offer_query(input query_t q, input int gap);
    query_t junk;
    if (gap > 0) begin
      junk = rand_query();
      req_if.valid    <= 1'b0;
      req_if.opcode   <= junk.opcode;
      req_if.center_x <= junk.center_x;
      req_if.center_y <= junk.center_y;
      req_if.radius_a <= junk.radius_a;
      req_if.p_x      <= junk.p_x;
      req_if.p_y      <= junk.p_y;
      req_if.q_x      <= junk.q_x;
      req_if.q_y      <= junk.q_y;
      req_if.radius_b <= junk.radius_b;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= q.opcode;
    req_if.center_x <= q.center_x;
    req_if.center_y <= q.center_y;
    req_if.radius_a <= q.radius_a;
    req_if.p_x      <= q.p_x;
    req_if.p_y      <= q.p_y;
    req_if.q_x      <= q.q_x;
    req_if.q_y      <= q.q_y;
    req_if.radius_b <= q.radius_b;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Result back-pressure: random stalls and ready runs, plus one long hold-off on request,
  // counted here so the sender can keep pushing and the pipe backs up into the query side.
  initial begin : rsp_ready_gen
    int stall_left, run_left, seen, r;
    stall_left   = 0;
    run_left     = 0;
    seen         = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_seq != seen) begin
        seen       = hold_off_seq;
        stall_left = 90;
        run_left   = 0;
      end
      if (stall_left == 0 && run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 30) stall_left = $urandom_range(1, 3);
        else if (r < 36) stall_left = $urandom_range(8, 30);
        run_left = (r > 88) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (run_left > 0) run_left--;
      end
    end
  end

  initial begin : stimulus
    query_t directed[$];
    query_t q;
    int     gap;
    req_if.valid    = 1'b0;
    req_if.opcode   = cct_pkg::OP_CIRCLE;
    req_if.center_x = '0;
    req_if.center_y = '0;
    req_if.radius_a = '0;
    req_if.p_x      = '0;
    req_if.p_y      = '0;
    req_if.q_x      = '0;
    req_if.q_y      = '0;
    req_if.radius_b = '0;
    rst_ni          = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Circle pairs: coincident points, far corners with maximum radii, exact touch and
    // one unit short of it, and junk in the ignored segment fields.
    directed.push_back(mk_query(cct_pkg::OP_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_query(cct_pkg::OP_CIRCLE, -32768, -32768, 32767,
                                32767, 32767, -1, -1, 32767));
    directed.push_back(mk_query(cct_pkg::OP_CIRCLE, 32767, 0, 32767,
                                -32768, 0, 0, 0, 32767));
    directed.push_back(mk_query(cct_pkg::OP_CIRCLE, 0, 0, 200, 300, 400, 0, 0, 300));
    directed.push_back(mk_query(cct_pkg::OP_CIRCLE, 0, 0, 200, 300, 400, 0, 0, 299));
    directed.push_back(mk_query(cct_pkg::OP_CIRCLE, -5, 7, 1, -5, 7, 32767, -32768, 0));
    // Zero-length segments, one at the corners of the range.
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 100, 50, 0, 50, 0, 0));
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 32767,
                                -32768, 32767, -32768, 32767, 32767));
    // Segment wholly inside the circle gives no hit.
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 1000, -10, 0, 10, 0, 0));
    // Touch at the start, touch at the end, tangent mid-segment and just past tangent.
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 100, 100, 0, 200, 0, 0));
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 100, 200, 0, 100, 0, 0));
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 100, -200, 100, 200, 100, 0));
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 100, -200, 101, 200, 101, 0));
    // Crossing through, one end inside, both outside with the vertex off either end.
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 100, -200, 0, 200, 0, 0));
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 100, 0, 0, 500, 0, 0));
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 100, 200, 0, 300, 0, 0));
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 100, -300, 0, -200, 0, 0));
    // Extremes: longest segments and largest radius, and a zero-radius point on the segment.
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 32767, 32767, 32767,
                                -32768, -32768, 32767, -32768, 32767));
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, -32768, -32768, 0,
                                -32768, -32768, 32767, 32767, 0));
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, 0, 0, 0,
                                -32768, 32767, 32767, -32768, 12345));
    directed.push_back(mk_query(cct_pkg::OP_SEGMENT, -32768, 32767, 32767,
                                32767, 32767, 32767, -32768, 0));

    foreach (directed[i]) offer_query(directed[i], sender_gap());

    // Pause the sender until the pipe is empty.
    drain_results();

    for (int i = 0; i < 400; i++) begin
      if (i == 150) drain_results();
      if (i == 250) begin
        // Long hold-off on the result side while queries keep coming back-to-back.
        hold_off_seq++;
        for (int k = 0; k < 40; k++) offer_query(rand_query(), 0);
        i += 40;
      end
      q   = rand_query();
      // Stretches with no idling at all, otherwise random gaps.
      gap = ((i % 60) < 15) ? 0 : sender_gap();
      offer_query(q, gap);
    end

    drain_results();
    repeat (10) @(posedge clk_i);

    $display("covered %0d queries: %0d circle pairs, %0d segments (%0d zero-length)",
             queries, queries - segments, segments, degen);
    $display("%0d hits seen, with random gaps and stalls on both channels", hits);
    if (errors == 0 && pending == 0) begin
      $display("circle_collision_test_top: match");
    end else begin
      $display("circle_collision_test_top: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cct_pkg.sv
hw/rtl/cct_ifs.sv
hw/rtl/cct_root_test.sv
hw/rtl/circle_collision_test_top.sv
tb/cct_collision_checker.sv
tb/circle_collision_test_top_tb.sv
